// ===== rtl/core/lbsd_pkg.sv =====
package lbsd_pkg;

  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int COPY_LEN_MIN = 3;
  localparam int COPY_LEN_MAX = 18;
  localparam logic [7:0] FILL_BYTE = 8'h20;
  localparam logic [7:0] LEN_MASK = 8'h0F;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;
  localparam logic [1:0] ST_TRUNC   = 2'd3;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_PLAIN  = 2'd1;
  localparam logic [1:0] CFG_PACKED = 2'd2;

  typedef enum logic [2:0] {
    K_NONE,
    K_BYTE,
    K_LIT,
    K_BLOCK,
    K_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [11:0] off;
    logic [3:0]  len;
    logic [1:0]  status;
  } cmd_t;

  typedef struct packed {
    logic        compressed_mode;
    logic [31:0] plain_length;
    logic [31:0] packed_length;
  } cfg_t;

endpackage

// ===== rtl/core/lbsd_ram.sv =====
module lbsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lbsd_cmd_fifo.sv =====
module lbsd_cmd_fifo import lbsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t din,
  input  logic rd,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        slots[wptr] <= din;
        wptr        <= ~wptr;
      end
      if (do_rd) begin
        rptr <= ~rptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/lbsd_front.sv =====
module lbsd_front import lbsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    PH_START, PH_STORED, PH_HDR_HI, PH_HDR_LO, PH_RAW, PH_BLOCK, PH_MATCH_HI, PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t     ph;
    logic [1:0] st;
  } pst_t;

  phase_t      phase, phase_next;
  logic [1:0]  status, status_next;
  logic [7:0]  header_high, header_high_next;
  logic [7:0]  match_offset_low, match_offset_low_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [3:0]  flag_bits_left, flag_bits_left_next;
  logic [15:0] raw_left, raw_left_next;
  logic [31:0] bytes_consumed, bytes_consumed_next;
  logic [31:0] block_end_mark, block_end_mark_next;
  logic [31:0] bytes_written, bytes_written_next;

  // Take every transition that needs no byte.
  function automatic pst_t settle(phase_t ph_in, logic [1:0] st_in, logic [15:0] raw,
                                  logic [31:0] cons, logic [31:0] endm,
                                  logic [31:0] wr, cfg_t c);
    pst_t r;
    r.ph = ph_in;
    r.st = st_in;
    if (r.ph == PH_START) begin
      r.ph = c.compressed_mode ? PH_HDR_HI : PH_STORED;
    end
    if ((r.ph == PH_RAW && raw == 16'd0) || (r.ph == PH_BLOCK && cons >= endm)) begin
      r.ph = PH_HDR_HI;
    end
    if (r.ph == PH_STORED && wr >= c.plain_length) begin
      r.st = ST_OK;
      r.ph = PH_DONE;
    end else if (r.ph == PH_HDR_HI && cons >= c.packed_length) begin
      r.st = (wr == c.plain_length) ? ST_OK : ST_CORRUPT;
      r.ph = PH_DONE;
    end
    return r;
  endfunction

  pst_t        pre, post;
  logic [15:0] hdr;
  logic [16:0] mag;
  logic [31:0] limit;
  phase_t      ph;
  logic [1:0]  st;

  always_comb begin
    phase_next            = phase;
    status_next           = status;
    header_high_next      = header_high;
    match_offset_low_next = match_offset_low;
    flag_bits_next        = flag_bits;
    flag_bits_left_next   = flag_bits_left;
    raw_left_next         = raw_left;
    bytes_consumed_next   = bytes_consumed;
    block_end_mark_next   = block_end_mark;
    bytes_written_next    = bytes_written;
    cmd.kind   = K_NONE;
    cmd.data   = in_byte;
    cmd.off    = {in_byte[7:4], match_offset_low};
    cmd.len    = in_byte[3:0];
    hdr        = {header_high, in_byte};
    mag        = 17'h10000 - {1'b0, hdr};
    limit      = cfg.plain_length - bytes_written;
    post       = '0;
    pre = settle(phase, status, raw_left, bytes_consumed, block_end_mark,
                 bytes_written, cfg);
    ph = pre.ph;
    st = pre.st;
    if (ph != PH_DONE) begin
      if (end_of_input) begin
        st = ST_TRUNC;
        ph = PH_DONE;
      end else begin
        bytes_consumed_next = bytes_consumed + 32'd1;
        unique case (ph)
          PH_STORED: begin
            cmd.kind = K_BYTE;
            bytes_written_next = bytes_written + 32'd1;
          end
          PH_HDR_HI: begin
            header_high_next = in_byte;
            ph = PH_HDR_LO;
          end
          PH_HDR_LO: begin
            if (hdr == 16'd0) begin
              st = (bytes_written == cfg.plain_length) ? ST_OK : ST_CORRUPT;
              ph = PH_DONE;
            end else if (hdr[15]) begin
              raw_left_next = (limit < {15'd0, mag}) ? limit[15:0] : mag[15:0];
              ph = PH_RAW;
            end else begin
              cmd.kind = K_BLOCK;
              block_end_mark_next = bytes_consumed_next + {16'd0, hdr};
              flag_bits_next = 8'd0;
              flag_bits_left_next = 4'd0;
              ph = PH_BLOCK;
            end
          end
          PH_RAW: begin
            cmd.kind = K_BYTE;
            bytes_written_next = bytes_written + 32'd1;
            raw_left_next = raw_left - 16'd1;
          end
          PH_BLOCK: begin
            if (flag_bits_left == 4'd0) begin
              flag_bits_next = in_byte;
              flag_bits_left_next = 4'd8;
            end else if (flag_bits[0]) begin
              cmd.kind = K_LIT;
              bytes_written_next = bytes_written + 32'd1;
              flag_bits_next = {1'b0, flag_bits[7:1]};
              flag_bits_left_next = flag_bits_left - 4'd1;
            end else begin
              match_offset_low_next = in_byte;
              ph = PH_MATCH_HI;
            end
          end
          PH_MATCH_HI: begin
            cmd.kind = K_COPY;
            bytes_written_next = bytes_written + 32'(in_byte & LEN_MASK)
                                 + 32'(COPY_LEN_MIN);
            flag_bits_next = {1'b0, flag_bits[7:1]};
            flag_bits_left_next = flag_bits_left - 4'd1;
            ph = PH_BLOCK;
          end
          default: begin
          end
        endcase
        post = settle(ph, st, raw_left_next, bytes_consumed_next, block_end_mark_next,
                      bytes_written_next, cfg);
        ph = post.ph;
        st = post.st;
      end
    end
    phase_next  = ph;
    status_next = st;
    cmd.status  = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      status           <= ST_RUN;
      header_high      <= 8'd0;
      match_offset_low <= 8'd0;
      flag_bits        <= 8'd0;
      flag_bits_left   <= 4'd0;
      raw_left         <= 16'd0;
      bytes_consumed   <= 32'd0;
      block_end_mark   <= 32'd0;
      bytes_written    <= 32'd0;
    end else if (accept) begin
      phase            <= phase_next;
      status           <= status_next;
      header_high      <= header_high_next;
      match_offset_low <= match_offset_low_next;
      flag_bits        <= flag_bits_next;
      flag_bits_left   <= flag_bits_left_next;
      raw_left         <= raw_left_next;
      bytes_consumed   <= bytes_consumed_next;
      block_end_mark   <= block_end_mark_next;
      bytes_written    <= bytes_written_next;
    end
  end

endmodule

// ===== rtl/core/lbsd_back.sv =====
module lbsd_back import lbsd_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic [1:0] done_status
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] START_POS = AW'(WINDOW_SIZE - COPY_LEN_MAX);

  typedef enum logic [1:0] {B_IDLE, B_READ, B_WRITE} bstate_t;

  bstate_t     state;
  logic [AW-1:0] wpos;
  logic [AW:0]   fill;
  logic [AW-1:0] src;
  logic [4:0]    left;
  logic [1:0]    cur_status;
  logic          hit;
  logic          out_valid;
  logic          slot_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_q;
  logic [7:0]    copy_byte;
  logic [AW-1:0] rel;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign cmd_pop   = (state == B_IDLE) && cmd_valid && slot_free;
  assign copy_byte = hit ? ram_q : FILL_BYTE;
  assign rel       = src - START_POS;
  assign ram_waddr = wpos;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = cmd.data;
    if (cmd_pop && cmd.kind == K_LIT) begin
      ram_we = 1'b1;
    end else if (state == B_WRITE && slot_free) begin
      ram_we    = 1'b1;
      ram_wdata = copy_byte;
    end
  end

  lbsd_ram #(.WIDTH(8), .DEPTH(WINDOW_SIZE)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == B_READ),
    .raddr (src),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      wpos      <= START_POS;
      fill      <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (cmd_pop) begin
            out_valid   <= 1'b1;
            out_byte    <= 8'd0;
            byte_valid  <= 1'b0;
            last_of_run <= 1'b1;
            done_status <= cmd.status;
            case (cmd.kind)
              K_BYTE: begin
                out_byte   <= cmd.data;
                byte_valid <= 1'b1;
              end
              K_LIT: begin
                out_byte   <= cmd.data;
                byte_valid <= 1'b1;
                wpos       <= wpos + 1'b1;
                if (!fill[AW]) begin
                  fill <= fill + 1'b1;
                end
              end
              K_BLOCK: begin
                wpos <= START_POS;
                fill <= '0;
              end
              K_COPY: begin
                out_valid  <= 1'b0;
                src        <= cmd.off[AW-1:0];
                left       <= {1'b0, cmd.len} + 5'(COPY_LEN_MIN);
                cur_status <= cmd.status;
                state      <= B_READ;
              end
              default: begin
              end
            endcase
          end
        end
        B_READ: begin
          hit   <= fill[AW] || (rel < fill[AW-1:0]);
          state <= B_WRITE;
        end
        B_WRITE: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            out_byte    <= copy_byte;
            byte_valid  <= 1'b1;
            last_of_run <= (left == 5'd1);
            done_status <= cur_status;
            wpos        <= wpos + 1'b1;
            src         <= src + 1'b1;
            left        <= left - 5'd1;
            if (!fill[AW]) begin
              fill <= fill + 1'b1;
            end
            state <= (left == 5'd1) ? B_IDLE : B_READ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lzss_block_stream_decompressor_top.sv =====
// Path: a non-match word taken on push is registered in the queue, then in the result
// register; a match word: queue, command pop, window read, write-back, first word out.
// Throughput: one archive word per cycle while the command queue has room; a match
// word yields its 3 to 18 plain words (window read, then write-back on a free slot).
// Each accepted word produces exactly one command, so 1 result, or up to 18 for a match.
// Reset (rst, synchronous, active high) empties queue and result register, restarts
// the parser and clears the configuration registers; the window needs no clearing.
module lzss_block_stream_decompressor_top import lbsd_pkg::*; #(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_run,
  output logic [1:0]  done_status
);

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce this.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   cfg.compressed_mode <= cfg_data[0];
        CFG_PLAIN:  cfg.plain_length    <= cfg_data;
        CFG_PACKED: cfg.packed_length   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: parse each word and turn it into a single command.
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic accept;
  logic q_empty;
  logic q_pop;

  assign accept = push && !full;

  lbsd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .cmd          (front_cmd)
  );

  // Short queue decouples parsing from the window copy engine.
  lbsd_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (accept),
    .din   (front_cmd),
    .rd    (q_pop),
    .dout  (back_cmd),
    .full  (full),
    .empty (q_empty)
  );

  // Back end: carry out commands against the history window, one result word at a time.
  lbsd_back #(.WINDOW_SIZE(WINDOW_SIZE)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (back_cmd),
    .cmd_valid   (!q_empty),
    .cmd_pop     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_of_run (last_of_run),
    .done_status (done_status)
  );

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("block not idle after reset");

  // A waiting result word is never dropped.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("result word lost");

  // Once a final status is given, later words keep a final status.
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && done_status != ST_RUN) |=> (empty || done_status != ST_RUN))
    else $error("status fell back to running");

  // A command is only taken from a queue that holds one.
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command taken from an empty queue");

endmodule
